FILE: rtl/bit_grid_cellular_automaton_defines.svh
// ----------------------------------------------------------------------------
// Bit grid cellular automaton assertion macros
// Concurrent assertion wrappers on clk_i and rst_ni, empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef BIT_GRID_CELLULAR_AUTOMATON_DEFINES_SVH
`define BIT_GRID_CELLULAR_AUTOMATON_DEFINES_SVH

`ifndef SYNTH
// Check on every clock edge outside reset.
`define BGCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check on every clock edge, reset included.
`define BGCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BGCA_ASSERT(lbl, prop, msg)
`define BGCA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/bgca_pkg.sv
// ----------------------------------------------------------------------------
// Bit grid cellular automaton package
// Field widths, operation codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package bgca_pkg;

  localparam int OP_W       = 2;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLUMNS = 2'd0,
    CFG_GRID_ROWS    = 2'd1
  } cfg_idx_e;

  localparam logic [CFG_DATA_W-1:0] GRID_COLUMNS_RESET = 7'd64;
  localparam logic [CFG_DATA_W-1:0] GRID_ROWS_RESET    = 7'd64;

  // A next-generation cell is live for exactly this neighbor count
  localparam logic [3:0] LIVE_COUNT = 4'd2;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_READ  = 3'd2,
    ST_GEN   = 3'd3,
    ST_DONE  = 3'd4
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/bgca_in_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one cell command per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgca_in_if;
  logic                        valid;
  logic                        ready;
  logic [bgca_pkg::OP_W-1:0]   op;
  logic [bgca_pkg::ROW_W-1:0]  cell_row;
  logic [bgca_pkg::COL_W-1:0]  cell_column;
  logic                        write_bit;

  modport source (output valid, output op, output cell_row, output cell_column,
                  output write_bit, input ready);
  modport sink   (input valid, input op, input cell_row, input cell_column,
                  input write_bit, output ready);
endinterface

`default_nettype wire

FILE: rtl/bgca_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result bit per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgca_out_if;
  logic valid;
  logic ready;
  logic read_bit;

  modport source (output valid, output read_bit, input ready);
  modport sink   (input valid, input read_bit, output ready);
endinterface

`default_nettype wire

FILE: rtl/bgca_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgca_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bgca_pkg::CFG_IDX_W-1:0]   index;
  logic [bgca_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/bgca_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bgca_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/bit_grid_cellular_automaton.sv
// ----------------------------------------------------------------------------
// Bit grid cellular automaton
// Bounded one-bit grid with cell write, cell read and generation step.
// ----------------------------------------------------------------------------
//   Channel   Dir   Beat contents
//   in_i      in    op, cell_row, cell_column, write_bit
//   cfg_i     in    index (0 grid_columns, 1 grid_rows), data
//   out_o     out   read_bit, one beat per command
//
// Write and unused ops go from idle straight to the done step, a read via the read step.
// A generation uses one shared RAM read port, which fetches each grid column three
//   cells at a time into a sliding 3x3 window.
// After reset both grid RAMs are cleared with in_i not ready; cfg_i is always ready.
// A stalled out_o holds the result; the next command is still taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bit_grid_cellular_automaton_defines.svh"

module bit_grid_cellular_automaton #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bgca_in_if.sink     in_i,
  bgca_cfg_if.sink    cfg_i,
  bgca_out_if.source  out_o
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RFW   = $clog2(MAX_ROWS + 1);
  localparam int RKW   = RFW + 1;
  localparam int CFW   = $clog2(MAX_COLUMNS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bgca_pkg::state_e state_q, state_d;

  logic [bgca_pkg::CFG_DATA_W-1:0] cols_q, rows_q;
  logic [CFW-1:0] cols_eff;
  logic [RFW-1:0] rows_eff;

  logic          bank_q, bank_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [RW-1:0] r_q, r_d;
  logic [CFW-1:0] f_q, f_d;
  logic [1:0]    k_q, k_d;
  logic          vld_q, vld_d;
  logic          top_q, top_d, mid_q, mid_d;
  logic [2:0]    wm_q, wm_d, wr_q, wr_d;
  logic          res_q, res_d;
  logic          out_valid_q, out_valid_d;
  logic          out_bit_q, out_bit_d;

  // RAM ports
  logic          we0, we1, wdata0, wdata1, rdata0, rdata1;
  logic [AW-1:0] waddr0, waddr1, raddr;

  logic          cur_we, cur_wdata, nxt_we, nxt_wdata, clr_act;
  logic [AW-1:0] cur_waddr, nxt_waddr;

  logic          in_accept, in_inside, rd_cur, bit_in, issue_ok, last_row;
  logic [AW-1:0] in_addr, gen_raddr, gen_waddr;
  logic [RKW-1:0] rk;
  logic [2:0]    new_col;
  logic [3:0]    cnt;

  // Size registers saturate to 1..MAX
  always_comb begin
    if (cols_q == '0) begin
      cols_eff = CFW'(1);
    end else if (32'(cols_q) > MAX_COLUMNS) begin
      cols_eff = CFW'(MAX_COLUMNS);
    end else begin
      cols_eff = CFW'(cols_q);
    end
    if (rows_q == '0) begin
      rows_eff = RFW'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      rows_eff = RFW'(MAX_ROWS);
    end else begin
      rows_eff = RFW'(rows_q);
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= bgca_pkg::GRID_COLUMNS_RESET;
      rows_q <= bgca_pkg::GRID_ROWS_RESET;
    end else if (cfg_i.valid) begin
      unique case (bgca_pkg::cfg_idx_e'(cfg_i.index))
        bgca_pkg::CFG_GRID_COLUMNS: cols_q <= cfg_i.data;
        bgca_pkg::CFG_GRID_ROWS:    rows_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign in_i.ready  = (state_q == bgca_pkg::ST_IDLE);
  assign in_accept   = in_i.valid && in_i.ready;
  assign in_inside   = (in_i.cell_row < rows_eff) && (in_i.cell_column < cols_eff);
  assign in_addr     = AW'(AW'(in_i.cell_row) * AW'(MAX_COLUMNS)) + AW'(in_i.cell_column);

  assign rd_cur  = bank_q ? rdata1 : rdata0;
  assign bit_in  = rd_cur & vld_q;

  // Fetch row r+k-1 of column f; rows and columns outside the grid read dead
  assign rk        = RKW'(r_q) + RKW'(k_q);
  assign issue_ok  = (k_q != 2'd3) && (rk != '0) && ((rk - RKW'(1)) < RKW'(rows_eff)) &&
                     (f_q < cols_eff);
  assign gen_raddr = AW'(AW'(rk - RKW'(1)) * AW'(MAX_COLUMNS)) + AW'(f_q);
  assign gen_waddr = AW'(AW'(r_q) * AW'(MAX_COLUMNS)) + AW'(f_q - CFW'(1));
  assign last_row  = ((RFW'(r_q) + RFW'(1)) == rows_eff);

  // Window after the shift: left = wm_q, center = wr_q, right = new_col
  assign new_col = {bit_in, mid_q, top_q};
  assign cnt = 4'(wm_q[0]) + 4'(wm_q[1]) + 4'(wm_q[2]) +
               4'(wr_q[0]) + 4'(wr_q[2]) +
               4'(new_col[0]) + 4'(new_col[1]) + 4'(new_col[2]);

  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    clr_d       = clr_q;
    r_d         = r_q;
    f_d         = f_q;
    k_d         = k_q;
    vld_d       = 1'b0;
    top_d       = top_q;
    mid_d       = mid_q;
    wm_d        = wm_q;
    wr_d        = wr_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_bit_d   = out_bit_q;
    clr_act     = 1'b0;
    cur_we      = 1'b0;
    cur_wdata   = in_i.write_bit;
    cur_waddr   = in_addr;
    nxt_we      = 1'b0;
    nxt_wdata   = (cnt == bgca_pkg::LIVE_COUNT);
    nxt_waddr   = gen_waddr;
    raddr       = gen_raddr;

    unique case (state_q)
      bgca_pkg::ST_CLEAR: begin
        clr_act = 1'b1;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = bgca_pkg::ST_IDLE;
        end
      end

      bgca_pkg::ST_IDLE: begin
        raddr = in_addr;
        if (in_accept) begin
          res_d   = 1'b0;
          state_d = bgca_pkg::ST_DONE;
          case (bgca_pkg::op_e'(in_i.op))
            bgca_pkg::OP_WRITE: begin
              cur_we = in_inside;
            end
            bgca_pkg::OP_READ: begin
              vld_d   = in_inside;
              state_d = bgca_pkg::ST_READ;
            end
            bgca_pkg::OP_STEP: begin
              r_d     = '0;
              f_d     = '0;
              k_d     = '0;
              wm_d    = '0;
              wr_d    = '0;
              state_d = bgca_pkg::ST_GEN;
            end
            default: ;
          endcase
        end
      end

      bgca_pkg::ST_READ: begin
        res_d   = bit_in;
        state_d = bgca_pkg::ST_DONE;
      end

      bgca_pkg::ST_GEN: begin
        vld_d = issue_ok;
        k_d   = k_q + 2'd1;
        case (k_q)
          2'd1: top_d = bit_in;
          2'd2: mid_d = bit_in;
          2'd3: begin
            wm_d   = wr_q;
            wr_d   = new_col;
            // Column f completes the window of cell f-1
            nxt_we = (f_q != '0);
            if (f_q == cols_eff) begin
              f_d  = '0;
              wm_d = '0;
              wr_d = '0;
              if (last_row) begin
                bank_d  = ~bank_q;
                res_d   = 1'b0;
                state_d = bgca_pkg::ST_DONE;
              end else begin
                r_d = r_q + RW'(1);
              end
            end else begin
              f_d = f_q + CFW'(1);
            end
          end
          default: ;
        endcase
      end

      bgca_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_bit_d   = res_q;
          state_d     = bgca_pkg::ST_IDLE;
        end
      end

      default: state_d = bgca_pkg::ST_IDLE;
    endcase
  end

  // Map current/next roles onto the two physical stores
  always_comb begin
    if (bank_q) begin
      we0    = clr_act | nxt_we;
      waddr0 = clr_act ? clr_q : nxt_waddr;
      wdata0 = !clr_act && nxt_wdata;
      we1    = clr_act | cur_we;
      waddr1 = clr_act ? clr_q : cur_waddr;
      wdata1 = !clr_act && cur_wdata;
    end else begin
      we0    = clr_act | cur_we;
      waddr0 = clr_act ? clr_q : cur_waddr;
      wdata0 = !clr_act && cur_wdata;
      we1    = clr_act | nxt_we;
      waddr1 = clr_act ? clr_q : nxt_waddr;
      wdata1 = !clr_act && nxt_wdata;
    end
  end

  bgca_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_grid0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (waddr0),
    .wdata_i (wdata0),
    .raddr_i (raddr),
    .rdata_o (rdata0)
  );

  bgca_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_grid1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr1),
    .wdata_i (wdata1),
    .raddr_i (raddr),
    .rdata_o (rdata1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bgca_pkg::ST_CLEAR;
      bank_q      <= 1'b0;
      clr_q       <= '0;
      r_q         <= '0;
      f_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      clr_q       <= clr_d;
      r_q         <= r_d;
      f_q         <= f_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vld_q     <= vld_d;
    top_q     <= top_d;
    mid_q     <= mid_d;
    wm_q      <= wm_d;
    wr_q      <= wr_d;
    res_q     <= res_d;
    out_bit_q <= out_bit_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.read_bit = out_bit_q;

  `BGCA_ASSERT(a_accept_leaves_idle, in_accept |=> (state_q != bgca_pkg::ST_IDLE), "beat accepted but sequencer stayed idle")
  `BGCA_ASSERT(a_gen_keeps_current, (state_q == bgca_pkg::ST_GEN) |-> !(bank_q ? we1 : we0), "current grid written during a generation")
  `BGCA_ASSERT(a_bank_flip_after_gen, (bank_q != $past(bank_q)) |-> $past(state_q == bgca_pkg::ST_GEN), "grid stores swapped outside a generation")
  `BGCA_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == bgca_pkg::ST_DONE), "result beat raised outside the done step")
  `BGCA_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_o.valid, "result valid during reset")

endmodule

`default_nettype wire
